>>> sv/bfaf_pkg.sv
// Shared types, constants and helpers of the block filter.
package bfaf_pkg;

   localparam int MaxOrder   = 16;
   localparam int OrderBits  = 4;
   localparam int SampleBits = 16;
   localparam int HistBits   = SampleBits + 8;
   localparam int CoefBits   = 18;
   localparam int CoefFrac   = 14;
   localparam int ScaleBits  = 24;
   localparam int ScaleFrac  = 16;
   localparam int SumBits    = 23;
   localparam int AccBits    = 48;
   localparam int DivBits    = 40;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_WR_NUM = 2'd1,
      CMD_WR_DEN = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FIR  = 2'd0,
      MODE_AR   = 2'd1,
      MODE_ARMA = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_ZEROS  = 2'd1,
      REG_POLES  = 2'd2,
      REG_BLKLEN = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_DIV, ST_DIVFIX, ST_SCALE, ST_MAC, ST_ROUND, ST_OUT
   } state_type;

   // Clamp a 5-bit order to 1..MaxOrder.
   function automatic logic [4:0] clamp_order(input logic [4:0] o);
      logic [4:0] r;
      r = o;
      if (o == 5'd0) r = 5'd1;
      else if (o > 5'(MaxOrder)) r = 5'(MaxOrder);
      return r;
   endfunction

   // Round off n fraction bits (add half, floor shift).
   function automatic logic signed [AccBits-1:0] round_sh(
      input logic signed [AccBits-1:0] v, input int n);
      logic signed [AccBits-1:0] t;
      t = v + (AccBits'(1) <<< (n - 1));
      return t >>> n;
   endfunction

   // Saturate to HistBits.
   function automatic logic signed [HistBits-1:0] sat_hist(
      input logic signed [AccBits-1:0] v);
      logic signed [AccBits-1:0] hi;
      logic signed [AccBits-1:0] lo;
      hi = (AccBits'(1) <<< (HistBits - 1)) - AccBits'(1);
      lo = -hi - AccBits'(1);
      if (v > hi) return hi[HistBits-1:0];
      if (v < lo) return lo[HistBits-1:0];
      return v[HistBits-1:0];
   endfunction

endpackage

>>> sv/block_fir_ar_arma_filter_top.sv
// Top level of the block FIR / autoregressive / ARMA filter.
// A sample word is filtered by one shared multiply-accumulate that walks
// the coefficient and history memories tap by tap, each tap an address
// phase then a multiply phase, with registered memory reads. The first
// sample of an ARMA block adds a coefficient sum pass and, unless the b
// sum is zero, a 40-step bit-serial gain division. Histories live in
// circular memories; a block start masks stale entries by a per-block
// fill count, so no clearing pass is needed after reset. Coefficient
// entries read as zero until written, by a valid bit per entry. Result
// words sit in an output register, and the next word is taken once the
// sample logic is idle and the result word has been taken.
module block_fir_ar_arma_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] cmd, [5:2] coeff_index, [23:6] coeff_value, [39:24] sample
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] filtered_sample
   output logic [15:0] rsp_tdata,
   // [0] gain_fault
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int HB = bfaf_pkg::HistBits;
   localparam int CB = bfaf_pkg::CoefBits;
   localparam int OB = bfaf_pkg::OrderBits;
   localparam int AB = bfaf_pkg::AccBits;
   localparam int DB = bfaf_pkg::DivBits;
   localparam logic signed [AB-1:0] SumHi =
      AB'((64'sd1 <<< (bfaf_pkg::SumBits - 1)) - 64'sd1);
   localparam logic signed [AB-1:0] SumLo = -SumHi - AB'(1);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [4:0]  zeros_ff, poles_ff;
   logic [15:0] blklen_ff;
   logic        csr_wr;
   bfaf_pkg::reg_type csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg = bfaf_pkg::reg_type'(csr_paddr[3:2]);

   // Hold register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bfaf_pkg::MODE_FIR;
         zeros_ff  <= 5'd1;
         poles_ff  <= 5'd1;
         blklen_ff <= 16'd512;
      end else if (csr_wr) begin
         unique case (csr_reg)
            bfaf_pkg::REG_MODE:   mode_ff   <= csr_pwdata[1:0];
            bfaf_pkg::REG_ZEROS:  zeros_ff  <= csr_pwdata[4:0];
            bfaf_pkg::REG_POLES:  poles_ff  <= csr_pwdata[4:0];
            bfaf_pkg::REG_BLKLEN: blklen_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Decode register reads
   always_comb begin
      unique case (csr_reg)
         bfaf_pkg::REG_MODE:   csr_prdata = {30'd0, mode_ff};
         bfaf_pkg::REG_ZEROS:  csr_prdata = {27'd0, zeros_ff};
         bfaf_pkg::REG_POLES:  csr_prdata = {27'd0, poles_ff};
         bfaf_pkg::REG_BLKLEN: csr_prdata = {16'd0, blklen_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // input word fields
   logic [1:0]           in_cmd;
   logic [OB-1:0]        in_idx;
   logic signed [CB-1:0] in_coef;
   logic signed [15:0]   in_samp;
   assign in_cmd  = req_tdata[1:0];
   assign in_idx  = req_tdata[5:2];
   assign in_coef = req_tdata[23:6];
   assign in_samp = req_tdata[39:24];

   // state and datapath registers
   bfaf_pkg::state_type st_ff, st_in;
   logic [4:0]            z_ff, p_ff;
   logic [1:0]            md_ff;
   logic [5:0]            k_ff, k_in;
   logic                  ph_ff, ph_in;
   logic signed [AB-1:0]  acc_ff, acc_in;
   logic signed [AB-1:0]  sb_ff, sb_in, sa_ff, sa_in;
   logic signed [15:0]    x_ff;
   logic signed [HB-1:0]  xin_ff, xin_in;
   logic [OB-1:0]         xptr_ff, yptr_ff;
   logic [4:0]            xfill_ff, yfill_ff;
   logic [15:0]           pos_ff;
   logic signed [23:0]    scale_ff, scale_in;
   logic                  fault_ff, fault_in;
   logic [DB-1:0]         rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic                  qneg_ff, qneg_in;
   logic signed [HB-1:0]  v_ff, v_in;
   logic                  first_ff, first_in;
   logic signed [CB-1:0]  cq_ff;
   logic signed [HB-1:0]  hq_ff;
   logic                  mvalid_ff, mvalid_in;
   logic signed [CB+HB-1:0] prod_ff;
   logic                  psub_ff, psub_in;

   // output register
   logic                  ov_ff;
   logic [15:0]           od_ff;
   logic                  olast_ff, ofault_ff;

   // memories
   logic          bw_en, aw_en, xw_en, yw_en;
   logic [OB-1:0] b_ra, a_ra, x_ra, y_ra, xw_a, yw_a;
   logic [CB-1:0] b_rd, a_rd;
   logic [HB-1:0] x_rd, y_rd, xw_d, yw_d;

   bfaf_ram #(.Width(CB), .Depth(bfaf_pkg::MaxOrder)) u_bram (
      .clock(clock), .wr_en(bw_en), .wr_addr(in_idx), .wr_data(in_coef),
      .rd_addr(b_ra), .rd_data(b_rd));
   bfaf_ram #(.Width(CB), .Depth(bfaf_pkg::MaxOrder)) u_aram (
      .clock(clock), .wr_en(aw_en), .wr_addr(in_idx), .wr_data(in_coef),
      .rd_addr(a_ra), .rd_data(a_rd));
   bfaf_ram #(.Width(HB), .Depth(bfaf_pkg::MaxOrder)) u_xram (
      .clock(clock), .wr_en(xw_en), .wr_addr(xw_a), .wr_data(xw_d),
      .rd_addr(x_ra), .rd_data(x_rd));
   bfaf_ram #(.Width(HB), .Depth(bfaf_pkg::MaxOrder)) u_yram (
      .clock(clock), .wr_en(yw_en), .wr_addr(yw_a), .wr_data(yw_d),
      .rd_addr(y_ra), .rd_data(y_rd));

   logic accept, is_samp;
   assign req_tready = (st_ff == bfaf_pkg::ST_IDLE) && !ov_ff;
   assign accept  = req_tvalid && req_tready;
   assign is_samp = in_cmd == bfaf_pkg::CMD_SAMPLE;
   assign bw_en = accept && in_cmd == bfaf_pkg::CMD_WR_NUM;
   assign aw_en = accept && in_cmd == bfaf_pkg::CMD_WR_DEN;

   // coefficient valid bits: unwritten entries read as zero
   logic [bfaf_pkg::MaxOrder-1:0] bvld_ff, avld_ff;
   logic                          bok_ff, aok_ff;
   logic signed [CB-1:0]          b_cf, a_cf;
   always_ff @(posedge clock) begin
      bok_ff <= bvld_ff[b_ra];
      aok_ff <= avld_ff[a_ra];
   end
   assign b_cf = bok_ff ? b_rd : '0;
   assign a_cf = aok_ff ? a_rd : '0;

   // tap bookkeeping: k counts taps of b (0..z-1) then a (z+1..z+p-1)
   logic [5:0] zc, pc;
   logic       in_b, in_a;
   logic [OB-1:0] tap_b, tap_a;
   assign zc = {1'b0, z_ff};
   assign pc = {1'b0, p_ff};
   assign in_b  = k_ff < zc;
   assign in_a  = (k_ff > zc) && (k_ff < zc + pc);
   assign tap_b = k_ff[OB-1:0];
   assign tap_a = 4'(k_ff - zc - 6'd1);   // history age m-1 for a[m]

   // Read addresses: sums and taps share the coefficient ports
   always_comb begin
      b_ra = tap_b;
      a_ra = (st_ff == bfaf_pkg::ST_SUM) ? 4'(k_ff - zc) : 4'(tap_a + 4'd1);
      x_ra = xptr_ff - tap_b;
      y_ra = yptr_ff - tap_a;
   end

   // masked history read: entries older than this block read as zero
   logic signed [HB-1:0] xh, yh;
   logic                  xh_ok, yh_ok;
   logic [5:0]            k_q;
   always_ff @(posedge clock) k_q <= k_ff;
   assign xh_ok = {1'b0, k_q[OB-1:0]} < xfill_ff;
   assign yh_ok = {1'b0, 4'(k_q - zc - 6'd1)} < yfill_ff;
   assign xh = xh_ok ? x_rd : '0;
   assign yh = yh_ok ? y_rd : '0;

   logic signed [23:0]      sx;
   logic signed [AB-1:0]    sxr;
   logic signed [AB-1:0]    vr;
   logic signed [AB-1:0]    sbs, sas;
   logic signed [DB:0]      dtry;
   logic                    blk_end;

   assign blk_end = pos_ff == (blklen_ff - 16'd1);

   // Next state and datapath control
   always_comb begin
      st_in = st_ff;  k_in = k_ff;  ph_in = ph_ff;
      acc_in = acc_ff; sb_in = sb_ff; sa_in = sa_ff;
      xin_in = xin_ff; scale_in = scale_ff; fault_in = fault_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; qneg_in = qneg_ff;
      v_in = v_ff; first_in = first_ff;
      mvalid_in = 1'b0; psub_in = 1'b0;
      xw_en = 1'b0; yw_en = 1'b0;
      xw_a = xptr_ff; yw_a = yptr_ff;
      xw_d = xin_ff;  yw_d = v_ff;
      sx = 24'(x_ff);
      sxr = bfaf_pkg::round_sh(AB'(scale_ff) * AB'(sx), bfaf_pkg::ScaleFrac);
      vr  = bfaf_pkg::round_sh(acc_ff, bfaf_pkg::CoefFrac);
      sbs = '0; sas = '0;
      dtry = {1'b0, rem_ff} - {1'b0, dvs_ff};
      unique case (st_ff)
         bfaf_pkg::ST_IDLE: begin
            if (accept && is_samp) begin
               first_in = pos_ff == 16'd0;
               if (pos_ff == 16'd0) fault_in = 1'b0;
               k_in = '0; sb_in = '0; sa_in = '0;
               if (pos_ff == 16'd0 && mode_ff == bfaf_pkg::MODE_ARMA)
                  st_in = bfaf_pkg::ST_SUM;
               else
                  st_in = bfaf_pkg::ST_SCALE;
            end
         end
         // Sum b then a, one entry per cycle, with read latency skew
         bfaf_pkg::ST_SUM: begin
            if (k_q < zc && k_ff != 6'd0 && k_q <= k_ff)
               sb_in = sb_ff + AB'(b_cf);
            else if (k_ff != 6'd0 && k_q >= zc && k_q < zc + pc)
               sa_in = sa_ff + AB'(a_cf);
            k_in = k_ff + 6'd1;
            if (k_ff == zc + pc) begin
               sbs = sb_in; sas = sa_in;
               if (sbs > SumHi) sbs = SumHi;
               if (sbs < SumLo) sbs = SumLo;
               if (sas > SumHi) sas = SumHi;
               if (sas < SumLo) sas = SumLo;
               if (sbs == '0) begin
                  fault_in = 1'b1;
                  scale_in = sas < 0 ? 24'sh800000 : 24'sh7FFFFF;
                  st_in = bfaf_pkg::ST_SCALE;
               end else begin
                  qneg_in = (sas < 0) != (sbs < 0);
                  rem_in = '0;
                  quo_in = DB'(sas < 0 ? -sas : sas) << bfaf_pkg::ScaleFrac;
                  dvs_in = DB'(sbs < 0 ? -sbs : sbs);
                  k_in = '0;
                  st_in = bfaf_pkg::ST_DIV;
               end
            end
         end
         // Restoring division, one quotient bit per cycle
         bfaf_pkg::ST_DIV: begin
            dtry = {rem_ff, quo_ff[DB-1]} - {1'b0, dvs_ff};
            if (!dtry[DB]) begin
               rem_in = dtry[DB-1:0];
               quo_in = {quo_ff[DB-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DB-2:0], quo_ff[DB-1]};
               quo_in = {quo_ff[DB-2:0], 1'b0};
            end
            k_in = k_ff + 6'd1;
            if (k_ff == 6'(DB - 1)) st_in = bfaf_pkg::ST_DIVFIX;
         end
         bfaf_pkg::ST_DIVFIX: begin
            if (!qneg_ff)
               scale_in = quo_ff > DB'(24'h7FFFFF) ? 24'sh7FFFFF : quo_ff[23:0];
            else
               scale_in = quo_ff > DB'(24'h800000) ? 24'sh800000 : 24'(-quo_ff);
            st_in = bfaf_pkg::ST_SCALE;
         end
         // Form the new input history word and push it
         bfaf_pkg::ST_SCALE: begin
            if (md_ff == bfaf_pkg::MODE_ARMA) xin_in = bfaf_pkg::sat_hist(sxr);
            else xin_in = HB'(x_ff);
            xw_a = xptr_ff + 4'd1; xw_d = xin_in; xw_en = 1'b1;
            k_in = '0; ph_in = 1'b0; acc_in = '0;
            st_in = bfaf_pkg::ST_MAC;
         end
         // Issue taps in turn, each with an address phase, then a multiply phase
         bfaf_pkg::ST_MAC: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               mvalid_in = (in_b && md_ff != bfaf_pkg::MODE_AR) ||
                           (in_a && (md_ff == bfaf_pkg::MODE_AR ||
                                     md_ff == bfaf_pkg::MODE_ARMA));
               psub_in = in_a;
               k_in = k_ff + 6'd1;
               if (k_ff >= zc + pc) st_in = bfaf_pkg::ST_ROUND;
            end
            if (psub_ff) acc_in = acc_ff - AB'(prod_ff);
            else if (mvalid_ff) acc_in = acc_ff + AB'(prod_ff);
         end
         bfaf_pkg::ST_ROUND: begin
            if (psub_ff) acc_in = acc_ff - AB'(prod_ff);
            else if (mvalid_ff) acc_in = acc_ff + AB'(prod_ff);
            if (!mvalid_ff && !psub_ff) begin
               if (md_ff == bfaf_pkg::MODE_AR)
                  acc_in = acc_ff + (AB'(xin_ff) <<< bfaf_pkg::CoefFrac);
               st_in = bfaf_pkg::ST_OUT;
            end
         end
         bfaf_pkg::ST_OUT: begin
            v_in = bfaf_pkg::sat_hist(vr);
            yw_a = yptr_ff + 4'd1; yw_d = v_in; yw_en = 1'b1;
            st_in = bfaf_pkg::ST_IDLE;
         end
         default: st_in = bfaf_pkg::ST_IDLE;
      endcase
   end

   // Multiply stage: operands registered from the memory reads, then the product
   always_ff @(posedge clock) begin
      cq_ff   <= in_b ? b_cf : a_cf;
      hq_ff   <= in_b ? xh : yh;
      prod_ff <= cq_ff * hq_ff;
   end

   logic sel_q, mv_q, ps_q;
   // Align the product with its valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_q <= 1'b0; ps_q <= 1'b0; mvalid_ff <= 1'b0; psub_ff <= 1'b0;
         sel_q <= 1'b0;
      end else begin
         mv_q <= mvalid_in && !psub_in;
         ps_q <= mvalid_in && psub_in;
         mvalid_ff <= mv_q;
         psub_ff   <= ps_q;
         sel_q <= 1'b0;
      end
   end

   logic signed [15:0] y_sat;
   always_comb begin
      if (v_in > HB'(16'sh7FFF) && v_in[HB-1] == 1'b0) y_sat = 16'sh7FFF;
      else if ($signed(v_in) < -HB'(17'sh8000)) y_sat = 16'sh8000;
      else y_sat = v_in[15:0];
   end

   // Advance state, positions, histories and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bfaf_pkg::ST_IDLE;
         pos_ff <= '0; xfill_ff <= '0; yfill_ff <= '0;
         xptr_ff <= '0; yptr_ff <= '0;
         scale_ff <= 24'sh010000; fault_ff <= 1'b0;
         ov_ff <= 1'b0; k_ff <= '0; ph_ff <= 1'b0; first_ff <= 1'b0;
         bvld_ff <= '0; avld_ff <= '0;
      end else begin
         st_ff <= st_in; k_ff <= k_in; ph_ff <= ph_in;
         scale_ff <= scale_in; fault_ff <= fault_in; first_ff <= first_in;
         if (bw_en) bvld_ff[in_idx] <= 1'b1;
         if (aw_en) avld_ff[in_idx] <= 1'b1;
         if (accept && is_samp && pos_ff == 16'd0) begin
            xfill_ff <= '0; yfill_ff <= '0;
         end
         if (xw_en) begin
            xptr_ff <= xw_a;
            if (xfill_ff != 5'(bfaf_pkg::MaxOrder)) xfill_ff <= xfill_ff + 5'd1;
         end
         if (yw_en) begin
            yptr_ff <= yw_a;
            if (yfill_ff != 5'(bfaf_pkg::MaxOrder)) yfill_ff <= yfill_ff + 5'd1;
            pos_ff <= blk_end ? 16'd0 : pos_ff + 16'd1;
            ov_ff <= 1'b1;
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in; sb_ff <= sb_in; sa_ff <= sa_in;
      xin_ff <= xin_in; rem_ff <= rem_in; quo_ff <= quo_in;
      dvs_ff <= dvs_in; qneg_ff <= qneg_in; v_ff <= v_in;
      if (accept && is_samp) begin
         x_ff <= in_samp;
         md_ff <= mode_ff;
         z_ff <= bfaf_pkg::clamp_order(zeros_ff);
         p_ff <= bfaf_pkg::clamp_order(poles_ff);
      end
      if (yw_en) begin
         od_ff <= y_sat;
         olast_ff <= blk_end;
         ofault_ff <= fault_ff && md_ff == bfaf_pkg::MODE_ARMA;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ofault_ff && !sel_q;

   // No new word while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !req_tready) else $error("word accepted while result pending");
   // A result appears only from the output stage
   a_out_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(ov_ff) |-> $past(st_ff) == bfaf_pkg::ST_OUT)
      else $error("result without output stage");
   // History fill never exceeds depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      xfill_ff <= 5'(bfaf_pkg::MaxOrder) && yfill_ff <= 5'(bfaf_pkg::MaxOrder))
      else $error("history fill out of range");
endmodule

>>> sv/bfaf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bfaf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
